/* sv/lat_pkg.sv */
// package for the logical address translator
// types, codes and default sizes; no dependencies
package lat_pkg;

  localparam int EXACT_DEPTH_DEF  = 256;
  localparam int SPAN_DEPTH_DEF   = 16;
  localparam int HANDLE_DEPTH_DEF = 1024;

  localparam logic [15:0] DATA_HANDLE_TOP = 16'hF000;
  localparam logic [15:0] FUNC_HANDLE_TOP = 16'hE000;

  localparam logic [2:0] OP_RESOLVE      = 3'd0;
  localparam logic [2:0] OP_INSERT_EXACT = 3'd1;
  localparam logic [2:0] OP_INSERT_SPAN  = 3'd2;
  localparam logic [2:0] OP_CLEAR_EXACT  = 3'd3;
  localparam logic [2:0] OP_CLEAR_SPANS  = 3'd4;
  localparam logic [2:0] OP_TO_HANDLE    = 3'd5;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_INVALID      = 3'd1;
  localparam logic [2:0] ST_HANDLE_SPACE = 3'd2;
  localparam logic [2:0] ST_DUPLICATE    = 3'd3;
  localparam logic [2:0] ST_SHADOWS      = 3'd4;
  localparam logic [2:0] ST_OVERLAP      = 3'd5;
  localparam logic [2:0] ST_FULL         = 3'd6;
  localparam logic [2:0] ST_BAD_HANDLE   = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] logical_addr;
    logic [31:0] interval_end;
    logic [63:0] host_addr;
  } req_t;

  typedef struct packed {
    logic [63:0] host_result;
    logic [31:0] logical_result;
    logic [2:0]  status;
  } rsp_t;

endpackage

/* sv/lat_stream_if.sv */
// valid/ready channel carrying one payload beat
// the payload type is given by the parameter T
interface lat_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/logical_address_translator_top.sv */
// logical address translator: exact table, interval table, handle table
// one item at a time, next item accepted in the cycle after its result beat;
// a resolve does a binary search of the exact table, then of the interval table,
// then a handle decode; an exact insert scans the exact table and shifts entries up,
// an interval insert scans both tables and shifts, a pointer conversion scans the
// issued handles; each table is read one entry at a time through its read port
// reset (synchronous, rst high) clears the counts and sets the next handle to one
module logical_address_translator_top import lat_pkg::*; #(
  parameter int EXACT_DEPTH  = EXACT_DEPTH_DEF,
  parameter int SPAN_DEPTH   = SPAN_DEPTH_DEF,
  parameter int HANDLE_DEPTH = HANDLE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  lat_stream_if.sink   in_ch,
  lat_stream_if.source out_ch
);

  localparam int EW = $clog2(EXACT_DEPTH);
  localparam int SW = (SPAN_DEPTH > 1) ? $clog2(SPAN_DEPTH) : 1;
  localparam int HW = $clog2(HANDLE_DEPTH);
  localparam int ECW = $clog2(EXACT_DEPTH + 1);
  localparam int SCW = $clog2(SPAN_DEPTH + 1);
  localparam int HCW = $clog2(HANDLE_DEPTH + 1);
  localparam int CW0 = (HCW > ECW) ? HCW : ECW;
  localparam int CW  = (SCW > CW0) ? SCW : CW0;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_EBS    = 5'd1;   // exact binary search issue
  localparam logic [4:0] S_EBSW   = 5'd2;   // exact search data
  localparam logic [4:0] S_ECHK   = 5'd3;
  localparam logic [4:0] S_ECHKW  = 5'd4;
  localparam logic [4:0] S_SBS    = 5'd5;
  localparam logic [4:0] S_SBSW   = 5'd6;
  localparam logic [4:0] S_SCHK   = 5'd7;
  localparam logic [4:0] S_SCHKW  = 5'd8;
  localparam logic [4:0] S_HRD    = 5'd9;
  localparam logic [4:0] S_HRDW   = 5'd10;
  localparam logic [4:0] S_ESCAN  = 5'd11;  // exact scan for insert checks
  localparam logic [4:0] S_ESCANW = 5'd12;
  localparam logic [4:0] S_SSCAN  = 5'd13;
  localparam logic [4:0] S_SSCANW = 5'd14;
  localparam logic [4:0] S_ESHIFT = 5'd15;
  localparam logic [4:0] S_ESHW   = 5'd16;
  localparam logic [4:0] S_SSHIFT = 5'd17;
  localparam logic [4:0] S_SSHW   = 5'd18;
  localparam logic [4:0] S_HSCAN  = 5'd19;
  localparam logic [4:0] S_HSCANW = 5'd20;
  localparam logic [4:0] S_OUT    = 5'd21;
  localparam logic [4:0] S_SADD   = 5'd22;

  // memories
  logic [31:0] ekey_mem [EXACT_DEPTH];
  logic [63:0] etgt_mem [EXACT_DEPTH];
  logic [31:0] sst_mem  [SPAN_DEPTH];
  logic [31:0] sen_mem  [SPAN_DEPTH];
  logic [63:0] stg_mem  [SPAN_DEPTH];
  logic [63:0] htg_mem  [HANDLE_DEPTH];

  logic [4:0]     state;
  req_t           req;
  rsp_t           rsp;
  logic [ECW-1:0] exact_count;
  logic [SCW-1:0] span_count;
  logic [HCW-1:0] next_handle;
  logic [CW:0]    lo, hi;      // search bounds, also scan index / shift index
  logic [CW:0]    pos;

  // memory ports
  logic           e_we;
  logic [EW-1:0]  e_wa, e_ra;
  logic [31:0]    e_wkey, e_rkey;
  logic [63:0]    e_wtgt, e_rtgt;
  logic           s_we;
  logic [SW-1:0]  s_wa, s_ra;
  logic [31:0]    s_wst, s_wen, s_rst, s_ren;
  logic [63:0]    s_wtg, s_rtg;
  logic           h_we;
  logic [HW-1:0]  h_wa, h_ra;
  logic [63:0]    h_wd, h_rd;

  always_ff @(posedge clk) begin
    if (e_we) begin
      ekey_mem[e_wa] <= e_wkey;
      etgt_mem[e_wa] <= e_wtgt;
    end
    e_rkey <= ekey_mem[e_ra];
    e_rtgt <= etgt_mem[e_ra];
  end
  always_ff @(posedge clk) begin
    if (s_we) begin
      sst_mem[s_wa] <= s_wst;
      sen_mem[s_wa] <= s_wen;
      stg_mem[s_wa] <= s_wtg;
    end
    s_rst <= sst_mem[s_ra];
    s_ren <= sen_mem[s_ra];
    s_rtg <= stg_mem[s_ra];
  end
  always_ff @(posedge clk) begin
    if (h_we) htg_mem[h_wa] <= h_wd;
    h_rd <= htg_mem[h_ra];
  end

  // shared helpers
  logic [CW:0]  mid;
  logic         hspace;
  logic [15:0]  hidx;
  logic [2:0]   ins_chk;
  assign mid    = lo + ((hi - lo) >> 1);
  assign hspace = (in_ch.data.logical_addr[31:16] == DATA_HANDLE_TOP) ||
                  (in_ch.data.logical_addr[31:16] == FUNC_HANDLE_TOP);
  assign hidx   = req.logical_addr[15:0];

  // argument checks of an incoming insert beat
  always_comb begin
    ins_chk = ST_OK;
    if (in_ch.data.logical_addr == 32'd0 || in_ch.data.host_addr == 64'd0 ||
        (in_ch.data.op == OP_INSERT_SPAN &&
         in_ch.data.interval_end <= in_ch.data.logical_addr))
      ins_chk = ST_INVALID;
    else if (hspace)
      ins_chk = ST_HANDLE_SPACE;
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = rsp;

  // memory address and write control
  always_comb begin
    e_we = 1'b0; e_wa = pos[EW-1:0]; e_wkey = req.logical_addr; e_wtgt = req.host_addr;
    e_ra = mid[EW-1:0];
    s_we = 1'b0; s_wa = pos[SW-1:0]; s_wst = req.logical_addr; s_wen = req.interval_end;
    s_wtg = req.host_addr;
    s_ra = mid[SW-1:0];
    h_we = 1'b0; h_wa = next_handle[HW-1:0]; h_wd = req.host_addr;
    h_ra = hidx[HW-1:0];
    unique case (state)
      S_ECHK, S_ESCAN: e_ra = lo[EW-1:0];
      S_SCHK:  s_ra = SW'(lo - 1'b1);
      S_SSCAN: s_ra = lo[SW-1:0];
      // handle allocation write when the scan ends without a match
      S_HSCAN: begin
        h_ra = lo[HW-1:0];
        h_we = !((HCW+1)'(lo) < (HCW+1)'(next_handle) &&
                 (HCW+1)'(lo) < (HCW+1)'(HANDLE_DEPTH)) &&
               (next_handle < HCW'(HANDLE_DEPTH));
      end
      S_ESHIFT: e_ra = EW'(hi - 1'b1);
      S_SSHIFT: s_ra = SW'(hi - 1'b1);
      S_ESHW: begin
        e_we = 1'b1;
        if (hi == pos) begin
          e_wa = pos[EW-1:0];
        end else begin
          e_wa = hi[EW-1:0]; e_wkey = e_rkey; e_wtgt = e_rtgt;
        end
      end
      S_SSHW: begin
        s_we = 1'b1;
        if (hi != pos) begin
          s_wa = hi[SW-1:0]; s_wst = s_rst; s_wen = s_ren; s_wtg = s_rtg;
        end
      end
      S_SADD: s_we = 1'b1;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      exact_count <= '0;
      span_count <= '0;
      next_handle <= HCW'(1);
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          req <= in_ch.data;
          lo  <= (in_ch.data.op == OP_TO_HANDLE) ? (CW+1)'(1) : '0;
          hi  <= (CW+1)'(exact_count);
          pos <= '0;
          case (in_ch.data.op) inside
            OP_RESOLVE: begin
              rsp <= '0;
              state <= (in_ch.data.logical_addr != 32'd0) ? S_EBS : S_OUT;
            end
            OP_INSERT_EXACT, OP_INSERT_SPAN: begin
              rsp <= '{64'd0, 32'd0, ins_chk};
              state <= (ins_chk == ST_OK) ? S_ESCAN : S_OUT;
            end
            OP_CLEAR_EXACT: begin
              exact_count <= '0; rsp <= '0; state <= S_OUT;
            end
            OP_CLEAR_SPANS: begin
              span_count <= '0; rsp <= '0; state <= S_OUT;
            end
            OP_TO_HANDLE: begin
              if (in_ch.data.host_addr[63:32] == 32'd0) begin
                rsp <= '{64'd0, in_ch.data.host_addr[31:0], ST_OK};
                state <= S_OUT;
              end else begin
                rsp <= '0;
                state <= S_HSCAN;
              end
            end
            default: begin
              rsp <= '{64'd0, 32'd0, ST_INVALID}; state <= S_OUT;
            end
          endcase
        end
        // exact lower-bound search
        S_EBS: if (lo < hi) state <= S_EBSW; else state <= S_ECHK;
        S_EBSW: begin
          if (e_rkey < req.logical_addr) lo <= mid + 1'b1; else hi <= mid;
          state <= S_EBS;
        end
        S_ECHK: begin
          if (lo < (CW+1)'(exact_count)) state <= S_ECHKW;
          else begin
            lo <= '0; hi <= (CW+1)'(span_count); state <= S_SBS;
          end
        end
        S_ECHKW: begin
          if (e_rkey == req.logical_addr) begin
            rsp.host_result <= e_rtgt; state <= S_OUT;
          end else begin
            lo <= '0; hi <= (CW+1)'(span_count); state <= S_SBS;
          end
        end
        // interval upper-bound search
        S_SBS: if (lo < hi) state <= S_SBSW; else state <= S_SCHK;
        S_SBSW: begin
          if (s_rst <= req.logical_addr) lo <= mid + 1'b1; else hi <= mid;
          state <= S_SBS;
        end
        S_SCHK: if (lo != '0) state <= S_SCHKW; else state <= S_HRD;
        S_SCHKW: begin
          if (req.logical_addr < s_ren) begin
            rsp.host_result <= s_rtg + {32'd0, req.logical_addr - s_rst};
            state <= S_OUT;
          end else state <= S_HRD;
        end
        // handle decode
        S_HRD: begin
          if (req.logical_addr[31:16] != DATA_HANDLE_TOP) begin
            rsp.host_result <= {32'd0, req.logical_addr}; state <= S_OUT;
          end else if (hidx == 16'd0 || 17'(hidx) >= 17'(next_handle) ||
                       32'(hidx) >= 32'(HANDLE_DEPTH)) begin
            rsp.status <= ST_BAD_HANDLE; state <= S_OUT;
          end else state <= S_HRDW;
        end
        S_HRDW: begin
          if (h_rd == 64'd0) rsp.status <= ST_BAD_HANDLE;
          else rsp.host_result <= h_rd;
          state <= S_OUT;
        end
        // exact walk: duplicate / insert point, or shadow check for spans
        S_ESCAN: begin
          if (lo < (CW+1)'(exact_count)) state <= S_ESCANW;
          else if (req.op == OP_INSERT_EXACT) begin
            pos <= lo;
            if (exact_count >= ECW'(EXACT_DEPTH)) begin
              rsp.status <= ST_FULL; state <= S_OUT;
            end else begin
              hi <= (CW+1)'(exact_count); state <= S_ESHIFT;
            end
          end else begin
            lo <= '0; pos <= (CW+1)'(span_count); state <= S_SSCAN;
          end
        end
        S_ESCANW: begin
          if (req.op == OP_INSERT_EXACT && e_rkey == req.logical_addr) begin
            rsp.status <= ST_DUPLICATE; state <= S_OUT;
          end else if (req.op == OP_INSERT_EXACT && e_rkey > req.logical_addr) begin
            pos <= lo;
            if (exact_count >= ECW'(EXACT_DEPTH)) begin
              rsp.status <= ST_FULL; state <= S_OUT;
            end else begin
              hi <= (CW+1)'(exact_count); state <= S_ESHIFT;
            end
          end else if (req.op != OP_INSERT_EXACT && e_rkey >= req.logical_addr &&
                       e_rkey < req.interval_end) begin
            rsp.status <= ST_SHADOWS; state <= S_OUT;
          end else begin
            lo <= lo + 1'b1; state <= S_ESCAN;
          end
        end
        // span walk: overlap and insert point (pos starts at count)
        S_SSCAN: begin
          if (lo < (CW+1)'(span_count)) state <= S_SSCANW;
          else if (span_count >= SCW'(SPAN_DEPTH)) begin
            rsp.status <= ST_FULL; state <= S_OUT;
          end else begin
            hi <= (CW+1)'(span_count); state <= S_SSHIFT;
          end
        end
        S_SSCANW: begin
          if (req.logical_addr < s_ren && req.interval_end > s_rst) begin
            rsp.status <= ST_OVERLAP; state <= S_OUT;
          end else begin
            if (s_rst >= req.logical_addr && pos > lo) pos <= lo;
            lo <= lo + 1'b1; state <= S_SSCAN;
          end
        end
        // shift up one entry at a time (read state, then write state), then place the new one
        S_ESHIFT: state <= S_ESHW;
        S_ESHW: begin
          if (hi == pos) begin
            exact_count <= exact_count + 1'b1; state <= S_OUT;
          end else begin
            hi <= hi - 1'b1; state <= S_ESHIFT;
          end
        end
        S_SSHIFT: if (hi == pos) state <= S_SADD; else state <= S_SSHW;
        S_SSHW: begin hi <= hi - 1'b1; state <= S_SSHIFT; end
        S_SADD: begin span_count <= span_count + 1'b1; state <= S_OUT; end
        // handle table walk
        S_HSCAN: begin
          if ((HCW+1)'(lo) < (HCW+1)'(next_handle) &&
              (HCW+1)'(lo) < (HCW+1)'(HANDLE_DEPTH)) state <= S_HSCANW;
          else if (next_handle >= HCW'(HANDLE_DEPTH)) begin
            rsp.status <= ST_FULL; state <= S_OUT;
          end else begin
            rsp.logical_result <= {DATA_HANDLE_TOP, 16'(next_handle)};
            next_handle <= next_handle + 1'b1;
            state <= S_OUT;
          end
        end
        S_HSCANW: begin
          if (h_rd == req.host_addr) begin
            rsp.logical_result <= {DATA_HANDLE_TOP, 16'(lo)}; state <= S_OUT;
          end else begin
            lo <= lo + 1'b1; state <= S_HSCAN;
          end
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    exact_count <= ECW'(EXACT_DEPTH)) else $error("exact count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(rsp))
    else $error("result changed while stalled");

endmodule

/* verif/testbench.sv */
// self-checking testbench for logical_address_translator_top
// depends on lat_pkg, lat_stream_if and the translator rtl
module testbench;
  import lat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EXACT_N  = EXACT_DEPTH_DEF;
  localparam int SPAN_N   = SPAN_DEPTH_DEF;
  localparam int HANDLE_N = HANDLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 3000;

  logic clk;
  logic rst;

  lat_stream_if #(.T(req_t)) in_ch (clk);
  lat_stream_if #(.T(rsp_t)) out_ch (clk);

  logical_address_translator_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the translator stores
  logic [31:0] sh_exact_keys [EXACT_N];
  logic [63:0] sh_exact_hosts [EXACT_N];
  int          sh_exact_count;
  logic [31:0] sh_span_lo [SPAN_N];
  logic [31:0] sh_span_hi [SPAN_N];
  logic [63:0] sh_span_hosts [SPAN_N];
  int          sh_span_count;
  logic [63:0] sh_handle_ptrs [HANDLE_N];
  int          sh_next_handle;

  req_t        pending_q [$];
  bit          pause_q [$];
  rsp_t        awaited_q [$];
  int          errors;
  int          beats_in;
  int          beats_out;
  int          status_seen [8];

  function automatic bit is_handle_space(logic [31:0] a);
    return a[31:16] == DATA_HANDLE_TOP || a[31:16] == FUNC_HANDLE_TOP;
  endfunction

  // translate or update the shadow stores for one request beat
  function automatic rsp_t translate(req_t r);
    rsp_t        p;
    int          pos;
    int          idx;
    bit          hit;
    logic [31:0] a;
    logic [31:0] e;
    logic [63:0] h;
    a = r.logical_addr;
    e = r.interval_end;
    h = r.host_addr;
    p = '0;
    p.status = ST_OK;
    case (r.op)
      OP_RESOLVE: begin
        hit = 1'b0;
        if (a == 32'd0) hit = 1'b1;
        for (int i = 0; i < sh_exact_count && !hit; i++) begin
          if (sh_exact_keys[i] == a) begin
            p.host_result = sh_exact_hosts[i];
            hit = 1'b1;
          end
        end
        if (!hit) begin
          pos = 0;
          while (pos < sh_span_count && sh_span_lo[pos] <= a) pos++;
          if (pos > 0 && a < sh_span_hi[pos-1]) begin
            p.host_result = sh_span_hosts[pos-1] + 64'(a - sh_span_lo[pos-1]);
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (a[31:16] == DATA_HANDLE_TOP) begin
            idx = int'(a[15:0]);
            if (idx == 0 || idx >= sh_next_handle || idx >= HANDLE_N ||
                sh_handle_ptrs[idx] == 64'd0)
              p.status = ST_BAD_HANDLE;
            else
              p.host_result = sh_handle_ptrs[idx];
          end else begin
            p.host_result = {32'd0, a};
          end
        end
      end
      OP_INSERT_EXACT: begin
        pos = 0;
        if (a == 32'd0 || h == 64'd0) p.status = ST_INVALID;
        else if (is_handle_space(a)) p.status = ST_HANDLE_SPACE;
        else begin
          while (pos < sh_exact_count && sh_exact_keys[pos] < a) pos++;
          if (pos < sh_exact_count && sh_exact_keys[pos] == a) p.status = ST_DUPLICATE;
          else if (sh_exact_count >= EXACT_N) p.status = ST_FULL;
          else begin
            for (int k = sh_exact_count; k > pos; k--) begin
              sh_exact_keys[k] = sh_exact_keys[k-1];
              sh_exact_hosts[k] = sh_exact_hosts[k-1];
            end
            sh_exact_keys[pos] = a;
            sh_exact_hosts[pos] = h;
            sh_exact_count++;
          end
        end
      end
      OP_INSERT_SPAN: begin
        pos = 0;
        if (a == 32'd0 || e <= a || h == 64'd0) p.status = ST_INVALID;
        else if (is_handle_space(a)) p.status = ST_HANDLE_SPACE;
        else begin
          for (int i = 0; i < sh_exact_count; i++)
            if (p.status == ST_OK && sh_exact_keys[i] >= a && sh_exact_keys[i] < e)
              p.status = ST_SHADOWS;
          for (int i = 0; i < sh_span_count; i++)
            if (p.status == ST_OK && a < sh_span_hi[i] && e > sh_span_lo[i])
              p.status = ST_OVERLAP;
          if (p.status == ST_OK) begin
            while (pos < sh_span_count && sh_span_lo[pos] < a) pos++;
            if (sh_span_count >= SPAN_N) p.status = ST_FULL;
            else begin
              for (int k = sh_span_count; k > pos; k--) begin
                sh_span_lo[k] = sh_span_lo[k-1];
                sh_span_hi[k] = sh_span_hi[k-1];
                sh_span_hosts[k] = sh_span_hosts[k-1];
              end
              sh_span_lo[pos] = a;
              sh_span_hi[pos] = e;
              sh_span_hosts[pos] = h;
              sh_span_count++;
            end
          end
        end
      end
      OP_CLEAR_EXACT: sh_exact_count = 0;
      OP_CLEAR_SPANS: sh_span_count = 0;
      OP_TO_HANDLE: begin
        hit = 1'b0;
        if (h[63:32] == 32'd0) begin
          p.logical_result = h[31:0];
          hit = 1'b1;
        end
        for (int i = 1; i < sh_next_handle && i < HANDLE_N && !hit; i++) begin
          if (sh_handle_ptrs[i] == h) begin
            p.logical_result = {DATA_HANDLE_TOP, 16'(i)};
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (sh_next_handle >= HANDLE_N) p.status = ST_FULL;
          else begin
            sh_handle_ptrs[sh_next_handle] = h;
            p.logical_result = {DATA_HANDLE_TOP, 16'(sh_next_handle)};
            sh_next_handle++;
          end
        end
      end
      default: p.status = ST_INVALID;
    endcase
    return p;
  endfunction

  // request driver: bursts with random gaps, optional drain pause
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    bit hold;
    if (rst) begin
      in_ch.valid <= 1'b0;
      burst_left <= 4;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_q.push_back(translate(pending_q[0]));
        void'(pending_q.pop_front());
        void'(pause_q.pop_front());
        beats_in++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        hold = pending_q.size() == 0 || gap_left > 0 ||
               (pause_q.size() > 0 && pause_q[0] && awaited_q.size() != 0);
        if (gap_left > 0) gap_left <= gap_left - 1;
        if (hold) begin
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_q[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // result monitor with its own stall pattern
  int stall_mode;
  int stall_cnt;

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_mode <= 0;
      stall_cnt <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        beats_out++;
        if (awaited_q.size() == 0) begin
          $error("result beat with nothing awaited");
          errors++;
        end else begin
          want = awaited_q.pop_front();
          status_seen[want.status]++;
          if (out_ch.data.host_result !== want.host_result) begin
            $error("host_result expected %h actual %h", want.host_result,
                   out_ch.data.host_result);
            errors++;
          end
          if (out_ch.data.logical_result !== want.logical_result) begin
            $error("logical_result expected %h actual %h", want.logical_result,
                   out_ch.data.logical_result);
            errors++;
          end
          if (out_ch.data.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_ch.data.status);
            errors++;
          end
        end
      end
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 300 == 299) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= (stall_cnt % 5 == 0);
        default: out_ch.ready <= (stall_cnt % 64) < 48;
      endcase
    end
  end

  // stimulus helpers
  logic [31:0] used_keys [$];
  logic [31:0] used_spans [$];

  task automatic push_item(logic [2:0] op, logic [31:0] a, logic [31:0] e,
                           logic [63:0] h, bit drain_first = 1'b0);
    req_t r;
    r.op = op;
    r.logical_addr = a;
    r.interval_end = e;
    r.host_addr = h;
    pending_q.push_back(r);
    pause_q.push_back(drain_first);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] pick_addr();
    logic [31:0] b;
    case ($urandom_range(0, 7))
      0, 1: return used_keys.size() ? used_keys[$urandom_range(0, used_keys.size()-1)]
                                   : $urandom();
      2, 3: begin
        b = used_spans.size() ? used_spans[$urandom_range(0, used_spans.size()-1)]
                              : $urandom();
        return b + $urandom_range(0, 300) - 20;
      end
      4: return {DATA_HANDLE_TOP, 16'($urandom_range(0, 40))};
      5: return {($urandom_range(0, 1) ? DATA_HANDLE_TOP : FUNC_HANDLE_TOP), 16'($urandom())};
      6: return $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(1, 4096);
      default: return $urandom();
    endcase
  endfunction

  logic [63:0] ptr_pool [8];

  initial begin
    logic [31:0] a;
    logic [31:0] len;
    rst = 1'b1;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    sh_exact_count = 0;
    sh_span_count = 0;
    sh_next_handle = 1;
    foreach (sh_handle_ptrs[i]) sh_handle_ptrs[i] = '0;
    foreach (ptr_pool[i]) ptr_pool[i] = {$urandom_range(1, 32'hFFFF_FFFF), $urandom()};

    // directed: edges and the error paths other than a full table
    push_item(OP_RESOLVE, 32'd0, 32'd0, 64'd0);
    push_item(OP_RESOLVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(OP_INSERT_EXACT, 32'd0, 32'd0, 64'd5);
    push_item(OP_INSERT_EXACT, 32'd7, 32'd0, 64'd0);
    push_item(OP_INSERT_EXACT, 32'hF000_0010, 32'd0, 64'd1);
    push_item(OP_INSERT_EXACT, 32'hE000_1234, 32'd0, 64'd1);
    push_item(OP_INSERT_EXACT, 32'h0000_1000, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(OP_INSERT_EXACT, 32'h0000_1000, 32'd0, 64'd9);
    push_item(OP_INSERT_SPAN, 32'h0000_2000, 32'h0000_2000, 64'd1);
    push_item(OP_INSERT_SPAN, 32'h0000_0F00, 32'h0000_1100, 64'd1);
    push_item(OP_INSERT_SPAN, 32'h0000_2000, 32'h0000_3000, 64'hFFFF_FFFF_FFFF_FF00);
    push_item(OP_INSERT_SPAN, 32'h0000_2800, 32'h0000_3800, 64'd1);
    push_item(OP_INSERT_SPAN, 32'hF000_0001, 32'hF000_0100, 64'd1);
    push_item(OP_RESOLVE, 32'h0000_1000, 32'd0, 64'd0);
    push_item(OP_RESOLVE, 32'h0000_2FFF, 32'd0, 64'd0);
    push_item(OP_RESOLVE, 32'h0000_3000, 32'd0, 64'd0);
    push_item(OP_RESOLVE, 32'hF000_0000, 32'd0, 64'd0);
    push_item(OP_RESOLVE, 32'hF000_0005, 32'd0, 64'd0);
    push_item(OP_TO_HANDLE, 32'd0, 32'd0, 64'd0);
    push_item(OP_TO_HANDLE, 32'd0, 32'd0, 64'h0000_0000_FFFF_FFFF);
    push_item(OP_TO_HANDLE, 32'd0, 32'd0, 64'h1234_5678_9ABC_DEF0);
    push_item(OP_TO_HANDLE, 32'd0, 32'd0, 64'h1234_5678_9ABC_DEF0);
    push_item(OP_RESOLVE, 32'hF000_0001, 32'd0, 64'd0);
    push_item(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(3'd7, 32'd1, 32'd1, 64'd1);
    push_item(OP_CLEAR_EXACT, 32'd0, 32'd0, 64'd0);
    push_item(OP_CLEAR_SPANS, 32'd0, 32'd0, 64'd0, 1'b1);

    // random mix of mostly well-formed table traffic
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 99)) inside
        [0:47]: push_item(OP_RESOLVE, pick_addr(), $urandom(), rand64());
        [48:66]: begin
          a = ($urandom_range(0, 4) == 0) ? pick_addr() : $urandom();
          if (used_keys.size() < 64) used_keys.push_back(a);
          push_item(OP_INSERT_EXACT, a, $urandom(),
                    ($urandom_range(0, 15) == 0) ? 64'd0 : rand64());
        end
        [67:79]: begin
          a = ($urandom_range(0, 4) == 0) ? pick_addr() : $urandom();
          len = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 256);
          if (used_spans.size() < 32) used_spans.push_back(a);
          push_item(OP_INSERT_SPAN, a, a + len,
                    ($urandom_range(0, 15) == 0) ? 64'd0 : rand64());
        end
        [80:91]: push_item(OP_TO_HANDLE, $urandom(), $urandom(),
                           ($urandom_range(0, 3) == 0) ? {32'd0, $urandom()}
                           : ptr_pool[$urandom_range(0, 7)]);
        [92:94]: begin
          push_item(OP_CLEAR_EXACT, $urandom(), $urandom(), rand64());
          used_keys.delete();
        end
        [95:97]: begin
          push_item(OP_CLEAR_SPANS, $urandom(), $urandom(), rand64());
          used_spans.delete();
        end
        default: push_item(3'($urandom_range(6, 7)), $urandom(), $urandom(), rand64());
      endcase
    end

    // fill the exact table past its depth
    push_item(OP_CLEAR_EXACT, 32'd0, 32'd0, 64'd0, 1'b1);
    push_item(OP_CLEAR_SPANS, 32'd0, 32'd0, 64'd0);
    for (int i = 0; i <= EXACT_N; i++)
      push_item(OP_INSERT_EXACT, 32'h1000_0000 + 32'(((i * 97) % (EXACT_N + 1)) * 16),
                32'd0, rand64());
    // fill the interval table past its depth, then probe both
    for (int i = 0; i <= SPAN_N; i++)
      push_item(OP_INSERT_SPAN, 32'h2000_0000 + 32'(((i * 5) % (SPAN_N + 1)) * 256),
                32'h2000_0080 + 32'(((i * 5) % (SPAN_N + 1)) * 256), rand64());
    for (int i = 0; i < 20; i++) begin
      push_item(OP_RESOLVE, 32'h1000_0000 + 32'($urandom_range(0, 300) * 16),
                32'd0, 64'd0);
      push_item(OP_RESOLVE, 32'h2000_0000 + 32'($urandom_range(0, 4700)), 32'd0, 64'd0);
    end

    // probe the handle space after a drain
    for (int i = 0; i < 16; i++)
      push_item(OP_RESOLVE, {DATA_HANDLE_TOP, 16'($urandom_range(0, HANDLE_N + 8))},
                32'd0, 64'd0, (i == 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (pending_q.size() == 0 && awaited_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d request beats, %0d result beats, table fills and all ops",
             beats_in, beats_out);
    $display("status counts ok %0d bad_handle %0d full %0d",
             status_seen[ST_OK], status_seen[ST_BAD_HANDLE], status_seen[ST_FULL]);
    if (errors == 0 && awaited_q.size() == 0)
      $display("[logical_address_translator_top] OK");
    else
      $display("[logical_address_translator_top] ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("[logical_address_translator_top] ERROR");
    $finish;
  end

endmodule
